>>> hw/rtl/etu_pkg.sv
`default_nettype none
package etu_pkg;

    // item handling modes set at stage 2; stage 4 can still make one invalid
    localparam logic [1:0] MODE_DIV  = 2'd0;  // weight computed through the chains
    localparam logic [1:0] MODE_INV  = 2'd1;  // no valid update
    localparam logic [1:0] MODE_FIX0 = 2'd2;  // diagonal, weight forced to zero
    localparam logic [1:0] MODE_FIX1 = 2'd3;  // diagonal, weight forced to one

    localparam logic CMD_ADJ  = 1'b0;
    localparam logic CMD_DIAG = 1'b1;

    // cells per chain
    localparam int DIV1_STEPS  = 31;
    localparam int SQRT1_STEPS = 31;
    localparam int DIV2_STEPS  = 21;
    localparam int SQRT2_STEPS = 19;

    localparam logic signed [17:0] LAM_HALF = 18'sd8192;
    localparam logic signed [17:0] LAM_ONE  = 18'sd16384;
    localparam logic [31:0]        TIME_MAX = 32'hFFFF_FFFF;

    // item context through the first divider
    typedef struct packed {
        logic               cmd;
        logic [1:0]         mode;
        logic               pos;
        logic [31:0]        u0;
        logic signed [32:0] du;
    } side_a_t;

    // context through the first root
    typedef struct packed {
        side_a_t     a;
        logic [31:0] sh;
        logic [30:0] c;
    } side_b_t;

    // context through the second divider
    typedef struct packed {
        side_a_t     a;
        logic [31:0] sh;
        logic        ovf;
    } side_c_t;

    // context through the second root
    typedef struct packed {
        logic [1:0]         mode;
        logic [31:0]        u0;
        logic signed [50:0] prod;
        logic [31:0]        sh;
        logic signed [17:0] lam;
        logic               sat;
    } side_d_t;

endpackage
`default_nettype wire

>>> hw/rtl/etu_div_cell.sv
`default_nettype none
module etu_div_cell #(
    parameter int DW = 32,
    parameter int QW = 31,
    parameter int SW = 8
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          en,
    input  wire logic          in_valid,
    input  wire logic [DW-1:0] rem_in,
    input  wire logic [DW-1:0] den_in,
    input  wire logic [QW-1:0] quo_in,
    input  wire logic [QW-1:0] lo_in,
    input  wire logic [SW-1:0] side_in,
    output logic               out_valid,
    output logic [DW-1:0]      rem_out,
    output logic [DW-1:0]      den_out,
    output logic [QW-1:0]      quo_out,
    output logic [QW-1:0]      lo_out,
    output logic [SW-1:0]      side_out
);

    logic          valid_reg;
    logic [DW-1:0] rem_reg, rem_next;
    logic [DW-1:0] den_reg;
    logic [QW-1:0] quo_reg, quo_next;
    logic [QW-1:0] lo_reg, lo_next;
    logic [SW-1:0] side_reg;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;

    // one restoring division step: bring down a bit, subtract if it fits
    always_comb begin
        trial    = {rem_in, lo_in[QW-1]};
        diff     = trial - {1'b0, den_in};
        ge       = (trial >= {1'b0, den_in});
        rem_next = ge ? diff[DW-1:0] : trial[DW-1:0];
        quo_next = {quo_in[QW-2:0], ge};
        lo_next  = {lo_in[QW-2:0], 1'b0};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg  <= rem_next;
            den_reg  <= den_in;
            quo_reg  <= quo_next;
            lo_reg   <= lo_next;
            side_reg <= side_in;
        end
    end

    assign out_valid = valid_reg;
    assign rem_out   = rem_reg;
    assign den_out   = den_reg;
    assign quo_out   = quo_reg;
    assign lo_out    = lo_reg;
    assign side_out  = side_reg;

endmodule
`default_nettype wire

>>> hw/rtl/etu_sqrt_cell.sv
`default_nettype none
module etu_sqrt_cell #(
    parameter int RW = 31,
    parameter int SW = 8
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            en,
    input  wire logic            in_valid,
    input  wire logic [RW+1:0]   rem_in,
    input  wire logic [RW-1:0]   root_in,
    input  wire logic [2*RW-1:0] rad_in,
    input  wire logic [SW-1:0]   side_in,
    output logic                 out_valid,
    output logic [RW+1:0]        rem_out,
    output logic [RW-1:0]        root_out,
    output logic [2*RW-1:0]      rad_out,
    output logic [SW-1:0]        side_out
);

    logic            valid_reg;
    logic [RW+1:0]   rem_reg, rem_next;
    logic [RW-1:0]   root_reg, root_next;
    logic [2*RW-1:0] rad_reg, rad_next;
    logic [SW-1:0]   side_reg;
    logic [RW+3:0]   acc;
    logic [RW+3:0]   tst;
    logic [RW+3:0]   diff;
    logic            ge;

    // one root digit: bring down two radicand bits, try root*4+1
    always_comb begin
        acc       = {rem_in, rad_in[2*RW-1:2*RW-2]};
        tst       = {2'b00, root_in, 2'b01};
        diff      = acc - tst;
        ge        = (acc >= tst);
        rem_next  = ge ? diff[RW+1:0] : acc[RW+1:0];
        root_next = {root_in[RW-2:0], ge};
        rad_next  = {rad_in[2*RW-3:0], 2'b00};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg  <= rem_next;
            root_reg <= root_next;
            rad_reg  <= rad_next;
            side_reg <= side_in;
        end
    end

    assign out_valid = valid_reg;
    assign rem_out   = rem_reg;
    assign root_out  = root_reg;
    assign rad_out   = rad_reg;
    assign side_out  = side_reg;

endmodule
`default_nettype wire

>>> hw/rtl/eikonal_triangle_update_const_quad_top.sv
`default_nettype none
// Channel   Direction  Fields (low bit first)
// s_        in         tdata: u_first[31:0], u_second[63:32], slowness[79:64]; tuser: cmd
// m_        out        tdata: new_time[31:0], weight[49:32], zero pad; tuser: invalid, saturated
// cfg_      in         wdata: grid_step
//
// One item per cycle unless the output stalls; uses two divider and two root cell chains.
// Reset clears all valid bits and loads grid_step with 1.0 (4096).
// A result held at m_ while m_tready is low freezes the whole pipeline, and s_tready
// drops in the same cycle; nothing else stalls.
module eikonal_triangle_update_const_quad_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [15:0] cfg_wdata,  // grid_step
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [79:0] s_tdata,    // u_first, u_second, slowness
    input  wire logic        s_tuser,    // cmd
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [55:0]      m_tdata,    // new_time, weight, pad
    output logic [1:0]       m_tuser     // invalid, saturated
);
    import etu_pkg::*;

    localparam int SAW = $bits(side_a_t);
    localparam int SBW = $bits(side_b_t);
    localparam int SCW = $bits(side_c_t);
    localparam int SDW = $bits(side_d_t);

    logic pipe_en;
    logic [15:0] grid_step_reg;

    // config register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_step_reg <= 16'd4096;
        end else if (cfg_we) begin
            grid_step_reg <= cfg_wdata;
        end
    end

    // stage 1: capture item, form s*h
    logic        s1_valid_reg;
    logic        s1_cmd_reg;
    logic [31:0] s1_u0_reg, s1_u1_reg, s1_sh_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            s1_cmd_reg <= s_tuser;
            s1_u0_reg  <= s_tdata[31:0];
            s1_u1_reg  <= s_tdata[63:32];
            s1_sh_reg  <= s_tdata[79:64] * grid_step_reg;
        end
    end

    // stage 2: classify, seed the first divider
    logic        s2_valid_reg;
    side_a_t     s2_side_reg, s2_side_next;
    logic [31:0] s2_sh_reg;
    logic [31:0] s2_rem_reg, s2_rem_next;
    logic [31:0] s2_mag;
    logic [39:0] s2_mag8;

    always_comb begin
        s2_side_next.cmd = s1_cmd_reg;
        s2_side_next.pos = (s1_u0_reg > s1_u1_reg);
        s2_side_next.u0  = s1_u0_reg;
        s2_side_next.du  = $signed({1'b0, s1_u0_reg}) - $signed({1'b0, s1_u1_reg});
        s2_mag  = s2_side_next.pos ? (s1_u0_reg - s1_u1_reg) : (s1_u1_reg - s1_u0_reg);
        s2_mag8 = {s2_mag, 8'h00};
        priority if (s1_sh_reg == 32'd0) begin
            s2_side_next.mode = MODE_INV;
        end else if (s1_cmd_reg == CMD_ADJ && s2_mag8 >= {7'd0, s1_sh_reg, 1'b0}) begin
            s2_side_next.mode = MODE_INV;
        end else if (s1_cmd_reg == CMD_DIAG && !s2_side_next.pos) begin
            s2_side_next.mode = MODE_FIX0;
        end else if (s1_cmd_reg == CMD_DIAG && s2_mag8 >= {8'd0, s1_sh_reg}) begin
            s2_side_next.mode = MODE_FIX1;
        end else begin
            s2_side_next.mode = MODE_DIV;
        end
        // first partial remainder is mag*2^7, below sh whenever the divide is used
        s2_rem_next = (s2_side_next.mode == MODE_DIV) ? {s2_mag[24:0], 7'd0} : 32'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            s2_side_reg <= s2_side_next;
            s2_sh_reg   <= s1_sh_reg;
            s2_rem_reg  <= s2_rem_next;
        end
    end

    // first divider chain: c = mag * 2^38 / sh
    logic           d1_v    [0:DIV1_STEPS];
    logic [31:0]    d1_rem  [0:DIV1_STEPS];
    logic [31:0]    d1_den  [0:DIV1_STEPS];
    logic [30:0]    d1_q    [0:DIV1_STEPS];
    logic [30:0]    d1_lo   [0:DIV1_STEPS];
    logic [SAW-1:0] d1_side [0:DIV1_STEPS];

    assign d1_v[0]    = s2_valid_reg;
    assign d1_rem[0]  = s2_rem_reg;
    assign d1_den[0]  = s2_sh_reg;
    assign d1_q[0]    = '0;
    assign d1_lo[0]   = '0;
    assign d1_side[0] = s2_side_reg;

    for (genvar i = 0; i < DIV1_STEPS; i++) begin : g_div1
        etu_div_cell #(.DW(32), .QW(31), .SW(SAW)) u_cell (
            .aclk(aclk), .aresetn(aresetn), .en(pipe_en),
            .in_valid(d1_v[i]), .rem_in(d1_rem[i]), .den_in(d1_den[i]),
            .quo_in(d1_q[i]), .lo_in(d1_lo[i]), .side_in(d1_side[i]),
            .out_valid(d1_v[i+1]), .rem_out(d1_rem[i+1]), .den_out(d1_den[i+1]),
            .quo_out(d1_q[i+1]), .lo_out(d1_lo[i+1]), .side_out(d1_side[i+1])
        );
    end

    // stage 3: c squared
    logic        s3_valid_reg;
    side_a_t     s3_side_reg;
    logic [31:0] s3_sh_reg;
    logic [30:0] s3_c_reg;
    logic [61:0] s3_c2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            s3_valid_reg <= d1_v[DIV1_STEPS];
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            s3_side_reg <= d1_side[DIV1_STEPS];
            s3_sh_reg   <= d1_den[DIV1_STEPS];
            s3_c_reg    <= d1_q[DIV1_STEPS];
            s3_c2_reg   <= d1_q[DIV1_STEPS] * d1_q[DIV1_STEPS];
        end
    end

    // stage 4: radicand 2 - c^2 or 1 - c^2, late invalid check
    logic        s4_valid_reg;
    side_b_t     s4_side_reg, s4_side_next;
    logic [61:0] s4_rad_reg, s4_rad_next;
    logic [61:0] s4_two, s4_one;

    always_comb begin
        s4_two = 62'd1 << 61;
        s4_one = 62'd1 << 60;
        s4_side_next.a  = s3_side_reg;
        s4_side_next.sh = s3_sh_reg;
        s4_side_next.c  = s3_c_reg;
        if (s3_side_reg.mode == MODE_DIV && s3_side_reg.cmd == CMD_ADJ
                && s3_c2_reg >= s4_two) begin
            s4_side_next.a.mode = MODE_INV;
        end
        s4_rad_next = (s3_side_reg.cmd == CMD_ADJ) ? (s4_two - s3_c2_reg)
                                                    : (s4_one - s3_c2_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s4_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            s4_side_reg <= s4_side_next;
            s4_rad_reg  <= s4_rad_next;
        end
    end

    // first root chain
    logic           r1_v    [0:SQRT1_STEPS];
    logic [32:0]    r1_rem  [0:SQRT1_STEPS];
    logic [30:0]    r1_root [0:SQRT1_STEPS];
    logic [61:0]    r1_rad  [0:SQRT1_STEPS];
    logic [SBW-1:0] r1_side [0:SQRT1_STEPS];

    assign r1_v[0]    = s4_valid_reg;
    assign r1_rem[0]  = '0;
    assign r1_root[0] = '0;
    assign r1_rad[0]  = s4_rad_reg;
    assign r1_side[0] = s4_side_reg;

    for (genvar i = 0; i < SQRT1_STEPS; i++) begin : g_sqrt1
        etu_sqrt_cell #(.RW(31), .SW(SBW)) u_cell (
            .aclk(aclk), .aresetn(aresetn), .en(pipe_en),
            .in_valid(r1_v[i]), .rem_in(r1_rem[i]), .root_in(r1_root[i]),
            .rad_in(r1_rad[i]), .side_in(r1_side[i]),
            .out_valid(r1_v[i+1]), .rem_out(r1_rem[i+1]), .root_out(r1_root[i+1]),
            .rad_out(r1_rad[i+1]), .side_out(r1_side[i+1])
        );
    end

    // stage 5: seed the second divider, flag quotient overflow
    logic        s5_valid_reg;
    side_c_t     s5_side_reg, s5_side_next;
    side_b_t     s5_in;
    logic [30:0] s5_den_reg, s5_den_next;
    logic [30:0] s5_rem_reg, s5_rem_next;
    logic [20:0] s5_lo_reg, s5_lo_next;
    logic [44:0] s5_dvd;
    logic [30:0] s5_hi;

    always_comb begin
        s5_in       = r1_side[SQRT1_STEPS];
        s5_den_next = (r1_root[SQRT1_STEPS] == 31'd0) ? 31'd1 : r1_root[SQRT1_STEPS];
        s5_dvd      = (s5_in.a.cmd == CMD_ADJ) ? {1'b0, s5_in.c, 13'd0} : {s5_in.c, 14'd0};
        s5_hi       = {7'd0, s5_dvd[44:21]};
        s5_side_next.a   = s5_in.a;
        s5_side_next.sh  = s5_in.sh;
        s5_side_next.ovf = (s5_hi >= s5_den_next);
        s5_rem_next = s5_side_next.ovf ? 31'd0 : s5_hi;
        s5_lo_next  = s5_dvd[20:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s5_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            s5_valid_reg <= r1_v[SQRT1_STEPS];
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            s5_side_reg <= s5_side_next;
            s5_den_reg  <= s5_den_next;
            s5_rem_reg  <= s5_rem_next;
            s5_lo_reg   <= s5_lo_next;
        end
    end

    // second divider chain: q = c * 2^13 or 2^14 over the root
    logic           d2_v    [0:DIV2_STEPS];
    logic [30:0]    d2_rem  [0:DIV2_STEPS];
    logic [30:0]    d2_den  [0:DIV2_STEPS];
    logic [20:0]    d2_q    [0:DIV2_STEPS];
    logic [20:0]    d2_lo   [0:DIV2_STEPS];
    logic [SCW-1:0] d2_side [0:DIV2_STEPS];

    assign d2_v[0]    = s5_valid_reg;
    assign d2_rem[0]  = s5_rem_reg;
    assign d2_den[0]  = s5_den_reg;
    assign d2_q[0]    = '0;
    assign d2_lo[0]   = s5_lo_reg;
    assign d2_side[0] = s5_side_reg;

    for (genvar i = 0; i < DIV2_STEPS; i++) begin : g_div2
        etu_div_cell #(.DW(31), .QW(21), .SW(SCW)) u_cell (
            .aclk(aclk), .aresetn(aresetn), .en(pipe_en),
            .in_valid(d2_v[i]), .rem_in(d2_rem[i]), .den_in(d2_den[i]),
            .quo_in(d2_q[i]), .lo_in(d2_lo[i]), .side_in(d2_side[i]),
            .out_valid(d2_v[i+1]), .rem_out(d2_rem[i+1]), .den_out(d2_den[i+1]),
            .quo_out(d2_q[i+1]), .lo_out(d2_lo[i+1]), .side_out(d2_side[i+1])
        );
    end

    // stage 6: weight with clamp or saturation
    logic               s6_valid_reg;
    side_c_t            s6_in;
    logic               s6_cmd_reg;
    logic [1:0]         s6_mode_reg;
    logic [31:0]        s6_u0_reg, s6_sh_reg;
    logic signed [32:0] s6_du_reg;
    logic signed [17:0] s6_lam_reg, s6_lam_next;
    logic               s6_sat_reg, s6_sat_next;
    logic [20:0]        s6_qc;
    logic signed [22:0] s6_lamw;

    always_comb begin
        s6_in = d2_side[DIV2_STEPS];
        if (s6_in.ovf || d2_q[DIV2_STEPS] > 21'h100000) begin
            s6_qc = 21'h100000;
        end else begin
            s6_qc = d2_q[DIV2_STEPS];
        end
        s6_lamw = s6_in.a.pos ? (23'sd8192 + $signed({2'b00, s6_qc}))
                              : (23'sd8192 - $signed({2'b00, s6_qc}));
        s6_sat_next = 1'b0;
        unique case (s6_in.a.mode)
            MODE_DIV: begin
                if (s6_in.a.cmd == CMD_ADJ) begin
                    if (s6_lamw > 23'sd131071) begin
                        s6_lam_next = 18'sh1FFFF;
                        s6_sat_next = 1'b1;
                    end else if (s6_lamw < -23'sd131072) begin
                        s6_lam_next = 18'sh20000;
                        s6_sat_next = 1'b1;
                    end else begin
                        s6_lam_next = s6_lamw[17:0];
                    end
                end else begin
                    s6_lam_next = (s6_qc > 21'd16384) ? LAM_ONE : $signed(s6_qc[17:0]);
                end
            end
            MODE_FIX1: s6_lam_next = LAM_ONE;
            MODE_FIX0: s6_lam_next = 18'sd0;
            MODE_INV:  s6_lam_next = 18'sd0;
            default:   s6_lam_next = 18'sd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s6_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            s6_valid_reg <= d2_v[DIV2_STEPS];
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            s6_cmd_reg  <= s6_in.a.cmd;
            s6_mode_reg <= s6_in.a.mode;
            s6_u0_reg   <= s6_in.a.u0;
            s6_du_reg   <= s6_in.a.du;
            s6_sh_reg   <= s6_in.sh;
            s6_lam_reg  <= s6_lam_next;
            s6_sat_reg  <= s6_sat_next;
        end
    end

    // stage 7: distance radicand and interpolation product
    logic               s7_valid_reg;
    side_d_t            s7_side_reg, s7_side_next;
    logic [37:0]        s7_g_reg, s7_g_next;
    logic signed [18:0] s7_m;
    logic signed [37:0] s7_sqm;

    always_comb begin
        s7_m   = (s6_cmd_reg == CMD_ADJ) ? ($signed({s6_lam_reg[17], s6_lam_reg}) - 19'sd8192)
                                         : $signed({s6_lam_reg[17], s6_lam_reg});
        s7_sqm = s7_m * s7_m;
        s7_g_next = (s6_cmd_reg == CMD_ADJ) ? ({s7_sqm[36:0], 1'b0} + (38'd1 << 27))
                                            : ({1'b0, s7_sqm[36:0]} + (38'd1 << 28));
        s7_side_next.mode = s6_mode_reg;
        s7_side_next.u0   = s6_u0_reg;
        s7_side_next.prod = s6_lam_reg * s6_du_reg;
        s7_side_next.sh   = s6_sh_reg;
        s7_side_next.lam  = s6_lam_reg;
        s7_side_next.sat  = s6_sat_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s7_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            s7_valid_reg <= s6_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            s7_side_reg <= s7_side_next;
            s7_g_reg    <= s7_g_next;
        end
    end

    // second root chain: distance factor in Q.14
    logic           r2_v    [0:SQRT2_STEPS];
    logic [20:0]    r2_rem  [0:SQRT2_STEPS];
    logic [18:0]    r2_root [0:SQRT2_STEPS];
    logic [37:0]    r2_rad  [0:SQRT2_STEPS];
    logic [SDW-1:0] r2_side [0:SQRT2_STEPS];

    assign r2_v[0]    = s7_valid_reg;
    assign r2_rem[0]  = '0;
    assign r2_root[0] = '0;
    assign r2_rad[0]  = s7_g_reg;
    assign r2_side[0] = s7_side_reg;

    for (genvar i = 0; i < SQRT2_STEPS; i++) begin : g_sqrt2
        etu_sqrt_cell #(.RW(19), .SW(SDW)) u_cell (
            .aclk(aclk), .aresetn(aresetn), .en(pipe_en),
            .in_valid(r2_v[i]), .rem_in(r2_rem[i]), .root_in(r2_root[i]),
            .rad_in(r2_rad[i]), .side_in(r2_side[i]),
            .out_valid(r2_v[i+1]), .rem_out(r2_rem[i+1]), .root_out(r2_root[i+1]),
            .rad_out(r2_rad[i+1]), .side_out(r2_side[i+1])
        );
    end

    // stage 8: travel cost and interpolated time
    logic               s8_valid_reg;
    side_d_t            s8_in;
    logic [1:0]         s8_mode_reg;
    logic signed [17:0] s8_lam_reg;
    logic               s8_sat_reg;
    logic signed [51:0] s8_interp_reg;
    logic [50:0]        s8_cost_reg;

    assign s8_in = r2_side[SQRT2_STEPS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s8_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            s8_valid_reg <= r2_v[SQRT2_STEPS];
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            s8_mode_reg   <= s8_in.mode;
            s8_lam_reg    <= s8_in.lam;
            s8_sat_reg    <= s8_in.sat;
            s8_interp_reg <= $signed({6'd0, s8_in.u0, 14'd0})
                             - $signed({s8_in.prod[50], s8_in.prod});
            s8_cost_reg   <= s8_in.sh * r2_root[SQRT2_STEPS];
        end
    end

    // stage 9: final sum, clip, output register
    logic               m_valid_reg;
    logic [31:0]        m_time_reg, m_time_next;
    logic signed [17:0] m_weight_reg, m_weight_next;
    logic               m_inv_reg, m_inv_next;
    logic               m_sat_reg, m_sat_next;
    logic signed [52:0] s9_total;
    logic [38:0]        s9_t;

    always_comb begin
        s9_total = $signed({s8_interp_reg[51], s8_interp_reg})
                   + $signed({10'd0, s8_cost_reg[50:8]});
        s9_t     = s9_total[52:14];
        m_weight_next = s8_lam_reg;
        m_inv_next    = 1'b0;
        m_sat_next    = s8_sat_reg;
        if (s8_mode_reg == MODE_INV) begin
            m_time_next   = TIME_MAX;
            m_weight_next = 18'sd0;
            m_inv_next    = 1'b1;
            m_sat_next    = 1'b0;
        end else if (s9_total < 53'sd0) begin
            m_time_next = 32'd0;
            m_sat_next  = 1'b1;
        end else if (s9_t[38:32] != 7'd0) begin
            m_time_next = TIME_MAX;
            m_sat_next  = 1'b1;
        end else begin
            m_time_next = s9_t[31:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            m_valid_reg <= s8_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            m_time_reg   <= m_time_next;
            m_weight_reg <= m_weight_next;
            m_inv_reg    <= m_inv_next;
            m_sat_reg    <= m_sat_next;
        end
    end

    // whole pipeline moves unless a held result blocks the output register
    assign pipe_en  = !m_valid_reg || m_tready;
    assign s_tready = pipe_en;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'd0, m_weight_reg, m_time_reg};
    assign m_tuser  = {m_sat_reg, m_inv_reg};

    // an invalid result carries the fixed answer
    a_inv_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_inv_reg |-> m_time_reg == TIME_MAX && m_weight_reg == 18'sd0
                                     && !m_sat_reg)
        else $error("invalid result with wrong payload");

    // no result straight out of reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid_reg)
        else $error("output valid after reset");

    // forced weights only for diagonal items
    a_fix_diag: assert property (@(posedge aclk) disable iff (!aresetn)
        s2_valid_reg && (s2_side_reg.mode == MODE_FIX0 || s2_side_reg.mode == MODE_FIX1)
        |-> s2_side_reg.cmd == CMD_DIAG)
        else $error("forced weight on adjacent item");

    // diagonal weight stays in [0, 1]
    a_diag_range: assert property (@(posedge aclk) disable iff (!aresetn)
        s6_valid_reg && s6_cmd_reg == CMD_DIAG |-> s6_lam_reg >= 18'sd0
                                                  && s6_lam_reg <= LAM_ONE)
        else $error("diagonal weight out of range");

    // a stalled pipeline keeps the held result
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !pipe_en |=> $stable(m_time_reg) && $stable(s8_valid_reg))
        else $error("pipeline moved while stalled");

endmodule
`default_nettype wire

>>> tb/etu_checker.sv
`timescale 1ns / 100ps
// Watches the channels of the triangle update block, predicts every result
// from the accepted item and the current grid step, and compares in order.
module etu_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [15:0] cfg_wdata,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [79:0] s_tdata,
    input  wire logic        s_tuser,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [55:0] m_tdata,
    input  wire logic [1:0]  m_tuser,
    output int               errors,
    output int               pending
);
    import etu_pkg::*;

    typedef struct {
        logic [31:0] new_time;
        logic [17:0] weight;
        logic        invalid;
        logic        saturated;
    } update_t;

    update_t     updates_due[$];
    logic [15:0] step_h;

    // floor integer square root
    function automatic logic [63:0] root_floor(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] b;
        v = v_in;
        r = 0;
        b = 64'h1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // one triangle update in fixed point
    function automatic update_t tri_update(input logic cmd, input logic [31:0] u0,
                                           input logic [31:0] u1, input logic [15:0] s,
                                           input logic [15:0] h);
        update_t     res;
        logic [63:0] sh;
        logic [63:0] mag8;
        logic [63:0] c;
        logic [63:0] r;
        logic [63:0] q;
        logic [63:0] g;
        logic [63:0] cost;
        logic [63:0] t;
        longint      du;
        longint      lam;
        longint      sq;
        longint      interp;
        longint      total;
        logic        pos;
        logic        sat;
        sh   = 64'(s) * 64'(h);
        du   = longint'(u0) - longint'(u1);
        mag8 = ((u0 >= u1) ? 64'(u0 - u1) : 64'(u1 - u0)) << 8;
        pos  = u0 > u1;
        sat  = 1'b0;
        res.new_time  = TIME_MAX;
        res.weight    = '0;
        res.invalid   = 1'b1;
        res.saturated = 1'b0;
        if (sh == 0 || (cmd == CMD_ADJ && mag8 >= 2 * sh)) return res;
        if (cmd == CMD_ADJ) begin
            c = (mag8 << 30) / sh;
            if (c * c >= (64'd2 << 60)) return res;
            r = root_floor((64'd2 << 60) - c * c);
            if (r == 0) r = 1;
            q = (c << 13) / r;
            if (q > (64'd1 << 20)) q = 64'd1 << 20;
            lam = pos ? 8192 + longint'(q) : 8192 - longint'(q);
            if (lam > 131071) begin
                lam = 131071;
                sat = 1'b1;
            end
            if (lam < -131072) begin
                lam = -131072;
                sat = 1'b1;
            end
            sq = lam - 8192;
            g  = 2 * 64'(sq * sq) + (64'd1 << 27);
        end else begin
            if (!pos) begin
                lam = 0;
            end else if (mag8 >= sh) begin
                lam = 16384;
            end else begin
                c = (mag8 << 30) / sh;
                r = root_floor((64'd1 << 60) - c * c);
                if (r == 0) r = 1;
                q = (c << 14) / r;
                lam = (q > 16384) ? 16384 : longint'(q);
            end
            g = 64'(lam * lam) + (64'd1 << 28);
        end
        // interpolated time plus travel cost
        interp = longint'(u0) * 16384 - lam * du;
        cost   = (sh * root_floor(g)) >> 8;
        total  = interp + longint'(cost);
        if (total < 0) begin
            res.new_time = '0;
            sat = 1'b1;
        end else begin
            t = 64'(total) >> 14;
            if (t > 64'(TIME_MAX)) begin
                res.new_time = TIME_MAX;
                sat = 1'b1;
            end else begin
                res.new_time = t[31:0];
            end
        end
        res.weight    = lam[17:0];
        res.invalid   = 1'b0;
        res.saturated = sat;
        return res;
    endfunction

    assign pending = updates_due.size();

    always @(posedge aclk) begin
        update_t want;
        int      bad;
        bad = 0;
        if (!aresetn) begin
            step_h <= 16'd4096;
            errors <= 0;
        end else begin
            if (cfg_we) step_h <= cfg_wdata;
            // predict on item acceptance
            if (s_tvalid && s_tready)
                updates_due.push_back(tri_update(s_tuser, s_tdata[31:0], s_tdata[63:32],
                                                 s_tdata[79:64], step_h));
            // compare on result acceptance
            if (m_tvalid && m_tready) begin
                if (updates_due.size() == 0) begin
                    $error("unexpected result tdata=%h tuser=%b", m_tdata, m_tuser);
                    bad++;
                end else begin
                    want = updates_due.pop_front();
                    if (m_tdata[31:0] !== want.new_time) begin
                        $error("new_time expected %h actual %h", want.new_time, m_tdata[31:0]);
                        bad++;
                    end
                    if (m_tdata[49:32] !== want.weight) begin
                        $error("weight expected %h actual %h", want.weight, m_tdata[49:32]);
                        bad++;
                    end
                    if (m_tuser[0] !== want.invalid) begin
                        $error("invalid expected %b actual %b", want.invalid, m_tuser[0]);
                        bad++;
                    end
                    if (m_tuser[1] !== want.saturated) begin
                        $error("saturated expected %b actual %b", want.saturated, m_tuser[1]);
                        bad++;
                    end
                end
            end
            if (bad != 0) errors <= errors + bad;
        end
    end
endmodule

>>> tb/tb_eikonal_triangle_update_const_quad_top.sv
`timescale 1ns / 100ps
module tb_eikonal_triangle_update_const_quad_top;
    import etu_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [15:0] cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [79:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;
    logic [1:0]  m_tuser;
    int          errors;
    int          pending;
    int          cycles = 0;
    int          items_sent = 0;
    logic        calm = 1'b0;
    logic        hold_req = 1'b0;
    logic        hold_done = 1'b0;
    logic [15:0] cur_h = 16'd4096;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    eikonal_triangle_update_const_quad_top i_dut (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    etu_checker i_checker (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .errors(errors), .pending(pending)
    );

    // watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // receiver: random back-pressure, one long hold-off on request
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_req && !hold_done) begin
                m_tready <= 1'b0;
                repeat (400) @(negedge aclk);
                hold_done <= 1'b1;
            end else begin
                m_tready <= calm ? 1'b1 : ($urandom_range(99) >= 30);
            end
        end
    end

    // offer one item, hold it until accepted; ends in the accepting posedge
    task automatic send_update(input logic cmd, input logic [31:0] u0,
                               input logic [31:0] u1, input logic [15:0] s);
        int gap;
        @(negedge aclk);
        if (!calm && $urandom_range(99) < 30) begin
            gap = $urandom_range(4, 1);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {s, u1, u0};
        s_tuser  <= cmd;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
    endtask

    // drain, settle, then write the grid step
    task automatic set_grid(input logic [15:0] h);
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (120) @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= h;
        cur_h = h;
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    // random item, mostly with a delta inside the well-posed range of c
    task automatic send_random();
        logic        cmd;
        logic [31:0] u0;
        logic [31:0] u1;
        logic [15:0] s;
        logic [63:0] span;
        logic [63:0] mag;
        cmd = $urandom_range(1);
        s   = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(8192, 1));
        u0  = $urandom;
        u1  = $urandom;
        if ($urandom_range(99) < 70) begin
            span = ((64'(s) * 64'(cur_h)) >> 7) + 2;
            mag  = 64'($urandom) % span;
            if ($urandom_range(1)) u1 = (64'(u0) >= mag) ? u0 - 32'(mag) : u0 + 32'(mag);
            else u1 = (64'(u0) + mag <= 64'hFFFF_FFFF) ? u0 + 32'(mag) : u0 - 32'(mag);
        end
        send_update(cmd, u0, u1, s);
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed items at reset grid step
        send_update(CMD_ADJ,  32'h0001_0000, 32'h0001_0000, 16'h1000);
        send_update(CMD_DIAG, 32'h0001_0000, 32'h0001_0000, 16'h1000);
        send_update(CMD_ADJ,  32'h0001_0000, 32'h0000_0000, 16'h0000);  // zero slowness
        send_update(CMD_DIAG, 32'h0001_0000, 32'h0000_0000, 16'h0000);
        send_update(CMD_ADJ,  32'h0003_0000, 32'h0000_0000, 16'h1000);  // c >= 2
        send_update(CMD_ADJ,  32'h0001_6A09, 32'h0000_0000, 16'h1000);  // c^2 just under 2
        send_update(CMD_ADJ,  32'h0000_0000, 32'h0001_6A09, 16'h1000);
        send_update(CMD_ADJ,  32'h0001_6A0A, 32'h0000_0000, 16'h1000);  // c^2 just over 2
        send_update(CMD_DIAG, 32'h0001_0000, 32'h0000_0000, 16'h1000);  // c exactly 1
        send_update(CMD_DIAG, 32'h0000_0000, 32'h0002_0000, 16'h1000);  // u0 below u1
        send_update(CMD_DIAG, 32'h0000_B505, 32'h0000_0000, 16'h1000);  // clamp region
        send_update(CMD_DIAG, 32'h0000_4000, 32'h0000_0000, 16'h1000);
        send_update(CMD_ADJ,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);  // time overflow
        send_update(CMD_DIAG, 32'hFFFF_FFFF, 32'hFFFF_0000, 16'hFFFF);
        send_update(CMD_ADJ,  32'h0000_0000, 32'h0000_0000, 16'hFFFF);
        send_update(CMD_DIAG, 32'h0000_0000, 32'hFFFF_FFFF, 16'h0001);
        set_grid(16'd1);
        send_update(CMD_ADJ,  32'h0000_0000, 32'h0000_0001, 16'h0001);  // tiny sh
        send_update(CMD_ADJ,  32'h0000_0001, 32'h0000_0000, 16'hFFFF);
        send_update(CMD_DIAG, 32'h0000_0001, 32'h0000_0000, 16'hFFFF);
        set_grid(16'hFFFF);
        send_update(CMD_ADJ,  32'h8000_0000, 32'h7FFF_0000, 16'hFFFF);
        send_update(CMD_DIAG, 32'h8000_0000, 32'h7FFF_0000, 16'hFFFF);

        // random phases over several grid steps
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: set_grid(16'd4096);
                1: set_grid(16'd1);
                2: set_grid(16'hFFFF);
                3: set_grid(16'd256);
                default: set_grid(16'($urandom_range(65535, 1)));
            endcase
            calm = (ph == 2);
            for (int k = 0; k < 75; k++) begin
                if (ph == 4 && k == 10) hold_req = 1'b1;
                send_random();
            end
        end
        calm = 1'b0;

        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending != 0 || !hold_done) @(negedge aclk);
        repeat (150) @(negedge aclk);

        $display("%0d items over six grid steps, both triangle kinds, with a long result stall",
                 items_sent);
        $display("%0d cycles run, %0d mismatches", cycles, errors);
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule

>>> files.f
hw/rtl/etu_pkg.sv
hw/rtl/etu_div_cell.sv
hw/rtl/etu_sqrt_cell.sv
hw/rtl/eikonal_triangle_update_const_quad_top.sv
tb/etu_checker.sv
tb/tb_eikonal_triangle_update_const_quad_top.sv
